// ===== src/igd_pkg.sv =====
`timescale 1ns / 1ps
package igd_pkg;
  localparam int unsigned MaxReference  = 1024;
  localparam int unsigned MaxPopulation = 256;
  localparam int unsigned MaxObjectives = 8;

  localparam int unsigned ObjW  = (MaxObjectives > 1) ? $clog2(MaxObjectives) : 1;
  localparam int unsigned PopW  = (MaxPopulation > 1) ? $clog2(MaxPopulation) : 1;
  localparam int unsigned RefW  = (MaxReference > 1) ? $clog2(MaxReference) : 1;
  localparam int unsigned NRefW = $clog2(MaxReference + 1);
  localparam int unsigned SumW  = NRefW + 32;
  localparam int unsigned DivCntW = $clog2(SumW);
  localparam int unsigned RefDepth = MaxReference * MaxObjectives;
  localparam int unsigned PopDepth = MaxPopulation * MaxObjectives;

  localparam int unsigned PAddrW = 4;

  typedef enum logic [1:0] {
    REQ_LOAD_REF = 2'd0,
    REQ_LOAD_POP = 2'd1,
    REQ_COMPUTE  = 2'd2,
    REQ_NONE     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    REG_OBJ = 2'd0,
    REG_POP = 2'd1,
    REG_REF = 2'd2,
    REG_NONE = 2'd3
  } reg_e;
endpackage

// ===== src/igd_if.sv =====
`timescale 1ns / 1ps
interface igd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [9:0]  point_index;
  logic [2:0]  objective_index;
  logic signed [31:0] coord_value;
  modport source (output valid, req_type, point_index, objective_index, coord_value,
                  input ready);
  modport sink (input valid, req_type, point_index, objective_index, coord_value,
                output ready);
endinterface

interface igd_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] mean_val;
  logic        saturated;
  modport source (output valid, mean_val, saturated, input ready);
  modport sink (input valid, mean_val, saturated, output ready);
endinterface

// ===== src/inverted_generational_distance_core.sv =====
`timescale 1ns / 1ps
// channel  | dir | handshake     | payload
// req_i    | in  | valid/ready   | req_type, point_index, objective_index, coord_value
// res_o    | out | valid/ready   | mean_val, saturated
// apb      | in  | psel/penable  | objective_count @0, population_count @4, reference_count @8
//
// A load beat is accepted whenever the core is idle. In a compute beat
// every coordinate pair passes one memory read, a subtract, the shared
// 32x32 multiplier and a saturating add; the root is one bit per cycle, the
// mean one quotient bit per cycle.
// Stores are not cleared at reset; registers return to 2, 256, 1024.
// A finished result waits in the output register while loads go on.
module inverted_generational_distance_core (
  input  logic clk_i,
  input  logic rst_ni,
  igd_req_if.sink   req_i,
  igd_res_if.source res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [igd_pkg::PAddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import igd_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RD   = 10'b0000000010,
    S_DIF  = 10'b0000000100,
    S_MUL  = 10'b0000001000,
    S_ACC  = 10'b0000010000,
    S_CMP  = 10'b0000100000,
    S_SQRT = 10'b0001000000,
    S_SUM  = 10'b0010000000,
    S_DIV  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_e;

  state_e state_q;

  logic [3:0]  obj_cnt_q;
  logic [8:0]  pop_cnt_q;
  logic [10:0] ref_cnt_q;

  logic [31:0] ref_mem [RefDepth];
  logic [31:0] pop_mem [PopDepth];
  logic [31:0] ref_rd_q, pop_rd_q;

  logic [ObjW-1:0] k_q, last_k_q;
  logic [PopW-1:0] j_q, last_j_q;
  logic [RefW-1:0] i_q, last_i_q;
  logic [NRefW-1:0] nref_q;

  logic [31:0] absd_q;
  logic [63:0] prod_q, acc_q, best_q, x_q, root_q, bit_q;
  logic        dsat_q, bsat_q, flag_q;
  logic [SumW-1:0] total_q;
  logic [NRefW-1:0] rem_q;
  logic [DivCntW-1:0] dcnt_q;

  logic [31:0] res_val_q;
  logic        res_sat_q, res_valid_q;

  // config decode
  logic wr_en;
  reg_e reg_sel;
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[3:2]);

  always_comb begin
    unique case (reg_sel)
      REG_OBJ: prdata = {28'd0, obj_cnt_q};
      REG_POP: prdata = {23'd0, pop_cnt_q};
      REG_REF: prdata = {21'd0, ref_cnt_q};
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_cnt_q <= 4'd2;
      pop_cnt_q <= 9'd256;
      ref_cnt_q <= 11'd1024;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_OBJ: obj_cnt_q <= pwdata[3:0];
        REG_POP: pop_cnt_q <= pwdata[8:0];
        REG_REF: ref_cnt_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // clamped counts
  logic [ObjW:0]  nobj;
  logic [PopW:0]  npop;
  logic [NRefW-1:0] nref;
  always_comb begin
    if (obj_cnt_q == '0) nobj = (ObjW+1)'(1);
    else if (32'(obj_cnt_q) > MaxObjectives) nobj = (ObjW+1)'(MaxObjectives);
    else nobj = (ObjW+1)'(obj_cnt_q);
    if (pop_cnt_q == '0) npop = (PopW+1)'(1);
    else if (32'(pop_cnt_q) > MaxPopulation) npop = (PopW+1)'(MaxPopulation);
    else npop = (PopW+1)'(pop_cnt_q);
    if (ref_cnt_q == '0) nref = NRefW'(1);
    else if (32'(ref_cnt_q) > MaxReference) nref = NRefW'(MaxReference);
    else nref = NRefW'(ref_cnt_q);
  end

  logic acc_in;
  req_e req;
  assign req_i.ready = (state_q == S_IDLE);
  assign acc_in      = req_i.valid && req_i.ready;
  assign req         = req_e'(req_i.req_type);

  // stores
  always_ff @(posedge clk_i) begin
    if (acc_in && req == REQ_LOAD_REF && 32'(req_i.point_index) < MaxReference &&
        32'(req_i.objective_index) < MaxObjectives)
      ref_mem[{req_i.point_index[RefW-1:0], req_i.objective_index[ObjW-1:0]}] <=
        req_i.coord_value;
    if (acc_in && req == REQ_LOAD_POP && 32'(req_i.point_index) < MaxPopulation &&
        32'(req_i.objective_index) < MaxObjectives)
      pop_mem[{req_i.point_index[PopW-1:0], req_i.objective_index[ObjW-1:0]}] <=
        req_i.coord_value;
  end

  always_ff @(posedge clk_i) begin
    ref_rd_q <= ref_mem[{i_q, k_q}];
    pop_rd_q <= pop_mem[{j_q, k_q}];
  end

  // datapath helpers
  logic signed [32:0] diff;
  logic [31:0] absd;
  logic [64:0] sum65;
  logic [63:0] acc_n;
  logic        dsat_n, take;
  logic [63:0] nbest;
  logic        nbsat;
  logic [63:0] trial;
  logic [NRefW:0] rem_n;

  always_comb begin
    diff   = {ref_rd_q[31], ref_rd_q} - {pop_rd_q[31], pop_rd_q};
    absd   = diff[32] ? 32'(-diff) : diff[31:0];
    sum65  = {1'b0, acc_q} + {1'b0, prod_q};
    acc_n  = sum65[64] ? '1 : sum65[63:0];
    dsat_n = dsat_q | sum65[64];
    take   = (j_q == '0) || (acc_q < best_q);
    nbest  = take ? acc_q : best_q;
    nbsat  = take ? dsat_q : bsat_q;
    trial  = root_q + bit_q;
    rem_n  = {rem_q, total_q[SumW-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && (!res_valid_q || res_o.ready)) res_valid_q <= 1'b1;
      else if (res_o.valid && res_o.ready) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (acc_in && req == REQ_COMPUTE) state_q <= S_RD;
        S_RD:   state_q <= S_DIF;
        S_DIF:  state_q <= S_MUL;
        S_MUL:  state_q <= S_ACC;
        S_ACC:  state_q <= (k_q == last_k_q) ? S_CMP : S_RD;
        S_CMP:  begin
          if (j_q != last_j_q) state_q <= S_RD;
          else if (nbsat) state_q <= S_SUM;
          else state_q <= S_SQRT;
        end
        S_SQRT: if (bit_q[0]) state_q <= S_SUM;
        S_SUM:  state_q <= (i_q == last_i_q) ? S_DIV : S_RD;
        S_DIV:  if (dcnt_q == DivCntW'(SumW - 1)) state_q <= S_OUT;
        S_OUT:  if (!res_valid_q || res_o.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        k_q      <= '0;
        j_q      <= '0;
        i_q      <= '0;
        last_k_q <= ObjW'(nobj - 1'b1);
        last_j_q <= PopW'(npop - 1'b1);
        last_i_q <= RefW'(nref - 1'b1);
        nref_q   <= nref;
        acc_q    <= '0;
        dsat_q   <= 1'b0;
        total_q  <= '0;
        flag_q   <= 1'b0;
      end
      S_DIF: absd_q <= absd;
      S_MUL: prod_q <= 64'(absd_q) * 64'(absd_q);
      S_ACC: begin
        acc_q  <= acc_n;
        dsat_q <= dsat_n;
        k_q    <= (k_q == last_k_q) ? '0 : k_q + 1'b1;
      end
      S_CMP: begin
        best_q <= nbest;
        bsat_q <= nbsat;
        acc_q  <= '0;
        dsat_q <= 1'b0;
        j_q    <= (j_q == last_j_q) ? '0 : j_q + 1'b1;
        x_q    <= nbest;
        bit_q  <= 64'd1 << 62;
        if (nbsat) begin
          root_q <= 64'hFFFF_FFFF;
          if (j_q == last_j_q) flag_q <= 1'b1;
        end else begin
          root_q <= '0;
        end
      end
      S_SQRT: begin
        if (x_q >= trial) begin
          x_q    <= x_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_SUM: begin
        total_q <= total_q + SumW'(root_q[31:0]);
        i_q     <= i_q + 1'b1;
        rem_q   <= '0;
        dcnt_q  <= '0;
      end
      S_DIV: begin
        if (rem_n >= {1'b0, nref_q}) begin
          rem_q   <= NRefW'(rem_n - {1'b0, nref_q});
          total_q <= {total_q[SumW-2:0], 1'b1};
        end else begin
          rem_q   <= rem_n[NRefW-1:0];
          total_q <= {total_q[SumW-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q + 1'b1;
      end
      S_OUT: begin
        if (!res_valid_q || res_o.ready) begin
          res_val_q <= total_q[31:0];
          res_sat_q <= flag_q;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.mean_val  = res_val_q;
  assign res_o.saturated = res_sat_q;
endmodule
